@@ rtl/core/murmur_pkg.sv @@
// ----------------------------------------------------------------------------
// murmur_pkg: shared definitions for the MurmurHash2A block
// Mix constant, datapath operation codes and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package murmur_pkg;

	localparam logic [31:0] MIX_MUL = 32'h5bd1_e995;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_KMIX,
		OP_HMIX,
		OP_KCNT,
		OP_FMUL,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic accept;
		op_t  op;
	} ctl_t;

	typedef struct packed {
		logic phase_full;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/core/murmur_dp.sv @@
// ----------------------------------------------------------------------------
// murmur_dp: MurmurHash2A datapath
// Hash, key and byte registers around one shared multiply-by-constant unit.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_dp import murmur_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        item_mode,
	input  wire logic [7:0]  item_byte,
	input  wire ctl_t        ctl,
	output      sts_t        sts,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] out_hash
);

	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] k_q;
	logic [23:0] partial_q;
	logic [1:0]  phase_q;
	logic [31:0] total_q;
	logic        open_q;
	logic        out_valid_q;
	logic [31:0] out_q;

	logic [31:0] eff_hash;
	logic [23:0] eff_partial;
	logic [1:0]  eff_phase;
	logic [31:0] eff_total;
	logic [31:0] mul_a;
	logic [31:0] product;
	logic        emit;

	assign eff_hash    = open_q ? hash_q : seed_q;
	assign eff_partial = open_q ? partial_q : 24'd0;
	assign eff_phase   = open_q ? phase_q : 2'd0;
	assign eff_total   = open_q ? total_q : 32'd0;

	always_comb begin
		case (ctl.op)
			OP_KMIX: mul_a = k_q ^ (k_q >> 24);
			OP_HMIX: mul_a = hash_q;
			OP_KCNT: mul_a = total_q;
			OP_FMUL: mul_a = hash_q ^ (hash_q >> 13);
			default: mul_a = item_mode ? {8'd0, eff_partial} : {item_byte, eff_partial};
		endcase
	end

	assign product = mul_a * MIX_MUL;
	assign emit    = (ctl.op == OP_EMIT) && sts.out_free;

	assign sts.phase_full = (eff_phase == 2'd3);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			hash_q      <= '0;
			partial_q   <= '0;
			phase_q     <= '0;
			total_q     <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				seed_q <= cfg_wr_data;
			if (ctl.accept) begin
				hash_q <= eff_hash;
				open_q <= 1'b1;
				if (item_mode) begin
					total_q   <= eff_total;
					partial_q <= '0;
					phase_q   <= '0;
				end else begin
					total_q <= eff_total + 32'd1;
					if (eff_phase == 2'd3) begin
						partial_q <= '0;
						phase_q   <= '0;
					end else begin
						partial_q <= eff_partial | (24'(item_byte) << {eff_phase, 3'b000});
						phase_q   <= eff_phase + 2'd1;
					end
				end
			end
			case (ctl.op)
				OP_HMIX: hash_q <= product ^ k_q;
				OP_FMUL: hash_q <= product;
				default: ;
			endcase
			if (emit) begin
				hash_q      <= hash_q ^ (hash_q >> 15);
				total_q     <= '0;
				open_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept || ctl.op == OP_KMIX || ctl.op == OP_KCNT)
			k_q <= product;
		if (emit)
			out_q <= hash_q ^ (hash_q >> 15);
	end

	assign out_valid = out_valid_q;
	assign out_hash  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/murmur_ctrl.sv @@
// ----------------------------------------------------------------------------
// murmur_ctrl: MurmurHash2A sequencer
// Steps the datapath through word mixes, the tail and count mixes and the finaliser.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_ctrl import murmur_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_mode,
	output      logic in_ready,
	input  wire sts_t sts,
	output      ctl_t ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WKMIX,
		S_WHMIX,
		S_TKMIX,
		S_THMIX,
		S_CKMUL,
		S_CKMIX,
		S_CHMIX,
		S_FMUL,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	op_t    op_q;
	logic   accept;

	assign accept     = in_valid && ready_q;
	assign in_ready   = ready_q;
	assign ctl.accept = accept;
	assign ctl.op     = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			op_q    <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_mode) begin
						state_q <= S_TKMIX;
						ready_q <= 1'b0;
						op_q    <= OP_KMIX;
					end else if (accept && sts.phase_full) begin
						state_q <= S_WKMIX;
						ready_q <= 1'b0;
						op_q    <= OP_KMIX;
					end
				end
				S_WKMIX: begin
					state_q <= S_WHMIX;
					op_q    <= OP_HMIX;
				end
				S_WHMIX: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
					op_q    <= OP_NONE;
				end
				S_TKMIX: begin
					state_q <= S_THMIX;
					op_q    <= OP_HMIX;
				end
				S_THMIX: begin
					state_q <= S_CKMUL;
					op_q    <= OP_KCNT;
				end
				S_CKMUL: begin
					state_q <= S_CKMIX;
					op_q    <= OP_KMIX;
				end
				S_CKMIX: begin
					state_q <= S_CHMIX;
					op_q    <= OP_HMIX;
				end
				S_CHMIX: begin
					state_q <= S_FMUL;
					op_q    <= OP_FMUL;
				end
				S_FMUL: begin
					state_q <= S_EMIT;
					op_q    <= OP_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
						op_q    <= OP_NONE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
					op_q    <= OP_NONE;
				end
			endcase
		end
	end

	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> op_q == OP_NONE)
		else $error("ready while a datapath step is issued");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && sts.out_free) |=> ready_q)
		else $error("emit did not return to idle");

	a_finish_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_mode) |=> (state_q == S_TKMIX && op_q == OP_KMIX))
		else $error("finish item did not start tail mix");

endmodule

`default_nettype wire

@@ rtl/core/murmur2a_incremental_hash.sv @@
// ----------------------------------------------------------------------------
// murmur2a_incremental_hash: incremental 32-bit MurmurHash2A over bytes
// Usage:
//   s_* channel: one item per byte. s_tuser is the mode (0 = add byte,
//   1 = finish), s_tdata the byte. The first item of a message loads the
//   seed register, written by the user through cfg_wr_en/cfg_wr_data while
//   idle; the block itself does not enforce this.
//   m_* channel: one item per finish, the finalised 32-bit hash.
// Sequence: add items are taken back to back; a word's fourth byte adds two
//   further multiplies. A finish runs the tail mix, count mix and finaliser,
//   and its emit step registers the hash for m_tdata; all seven multiplies
//   share one 32x32 constant multiplier, one per cycle.
// Reset: seed, hash state and output valid flag cleared; no message open.
// Stall: a held result does not block new add items; a further finish
//   waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2a_incremental_hash import murmur_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
	input  wire logic        s_tuser,   // [0] mode
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata    // [31:0] hash_value
);

	ctl_t ctl;
	sts_t sts;

	murmur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	murmur_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_mode   (s_tuser),
		.item_byte   (s_tdata),
		.ctl         (ctl),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_hash    (m_tdata)
	);

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for murmur2a_incremental_hash
// Streams byte messages, each closed by a finish item, through the block.
// Every accepted item feeds a behavioural hash predictor. Every emitted hash
// is checked against the oldest predicted one; the seed is rewritten after
// draining, once mid-message. Both sides idle at random under two profiles
// and not in a third; one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------

module tb_top;
	import murmur_pkg::*;

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 188;
	localparam int N_ROWS       = 26;

	typedef enum logic [0:0] {
		ROW_ITEM,
		ROW_SEED
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        mode;
		logic [31:0] value;
		logic        fixed_ok;
		logic [31:0] fixed;
	} stim_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata     = '0;
	logic        s_tuser     = 1'b0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [31:0] m_tdata;

	// predictor state
	logic [31:0] seed_reg;
	logic [31:0] acc_hash;
	logic [23:0] tail_bytes;
	logic [1:0]  tail_count;
	logic [31:0] byte_count;
	logic        msg_open;

	logic [31:0] expected_hashes [$];

	int  send_idle_pct = 28;
	int  recv_idle_pct = 73;
	bit  hold_toggle   = 1'b0;
	int  n_errors      = 0;
	int  items_sent    = 0;
	int  hashes_seen   = 0;
	int  seed_writes   = 0;

	stim_row_t directed_rows [N_ROWS];

	murmur2a_incremental_hash dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] murmur_mix(logic [31:0] h, logic [31:0] k);
		k = k * MIX_MUL;
		k = k ^ (k >> 24);
		k = k * MIX_MUL;
		return (h * MIX_MUL) ^ k;
	endfunction

	task automatic absorb_item(logic mode, logic [7:0] b, logic fixed_ok, logic [31:0] fixed);
		logic [31:0] h;
		if (!msg_open) begin
			acc_hash   = seed_reg;
			tail_bytes = '0;
			tail_count = '0;
			byte_count = '0;
			msg_open   = 1'b1;
		end
		if (mode == MODE_ADD) begin
			byte_count = byte_count + 32'd1;
			if (tail_count == 2'd3) begin
				acc_hash   = murmur_mix(acc_hash, {b, tail_bytes});
				tail_bytes = '0;
				tail_count = '0;
			end else begin
				tail_bytes = tail_bytes | (24'(b) << (8 * tail_count));
				tail_count = tail_count + 2'd1;
			end
		end else begin
			h = murmur_mix(acc_hash, {8'h00, tail_bytes});
			h = murmur_mix(h, byte_count);
			h = h ^ (h >> 13);
			h = h * MIX_MUL;
			h = h ^ (h >> 15);
			expected_hashes.push_back(fixed_ok ? fixed : h);
			acc_hash   = h;
			tail_bytes = '0;
			tail_count = '0;
			byte_count = '0;
			msg_open   = 1'b0;
		end
	endtask

	task automatic send_item(logic mode, logic [7:0] b, logic fixed_ok, logic [31:0] fixed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_item(mode, b, fixed_ok, fixed);
		items_sent++;
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_item(MODE_ADD, 8'($urandom), 1'b0, '0);
		send_item(MODE_FINISH, 8'($urandom), 1'b0, '0);
	endtask

	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] value);
		drain_outputs();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		seed_reg = value;
		seed_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			hashes_seen++;
			if (expected_hashes.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected hash, expected none, actual %h", $time, m_tdata);
			end else if (m_tdata !== expected_hashes[0]) begin
				n_errors++;
				$display("%0t: hash mismatch, expected %h, actual %h",
					$time, expected_hashes[0], m_tdata);
				void'(expected_hashes.pop_front());
			end else begin
				void'(expected_hashes.pop_front());
			end
		end
	end

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		bit hold_seen;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Timeout with %0d hashes outstanding", expected_hashes.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [31:0] phase_seed;
		int          target;
		int          r;

		seed_reg   = '0;
		acc_hash   = '0;
		tail_bytes = '0;
		tail_count = '0;
		byte_count = '0;
		msg_open   = 1'b0;

		directed_rows = '{
			'{ROW_ITEM, MODE_FINISH, 32'h00, 1'b1, 32'h0},   // empty message, zero seed
			'{ROW_ITEM, MODE_FINISH, 32'hff, 1'b1, 32'h0},   // byte ignored on finish
			'{ROW_ITEM, MODE_ADD,    32'h00, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'hff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h80, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h01, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'h00, 1'b0, 32'h0},
			'{ROW_SEED, MODE_ADD,    32'hffff_ffff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'h5a, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'hff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'hff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'hff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'hff, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h00, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'h00, 1'b0, 32'h0},
			'{ROW_SEED, MODE_ADD,    32'ha5a5_a5a5, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h01, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h02, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h04, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h08, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h10, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'haa, 1'b0, 32'h0},
			// seed rewritten mid-message: the open message keeps the old one
			'{ROW_ITEM, MODE_ADD,    32'h7e, 1'b0, 32'h0},
			'{ROW_SEED, MODE_ADD,    32'h0000_0000, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_ADD,    32'h55, 1'b0, 32'h0},
			'{ROW_ITEM, MODE_FINISH, 32'h00, 1'b0, 32'h0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_SEED)
				write_seed(directed_rows[i].value);
			else
				send_item(directed_rows[i].mode, directed_rows[i].value[7:0],
					directed_rows[i].fixed_ok, directed_rows[i].fixed);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				1:       phase_seed = 32'hffff_ffff;
				2:       phase_seed = 32'h0000_0000;
				4:       phase_seed = 32'h8000_0000;
				default: phase_seed = $urandom;
			endcase
			write_seed(phase_seed);
			case (p / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			// long output stall with short messages queued up behind it
			if (p == 1) begin
				hold_toggle <= ~hold_toggle;
				for (int m = 0; m < 12; m++)
					send_message($urandom_range(2));
			end

			target = N_ROWS + (p + 1) * PHASE_ITEMS;
			while (items_sent < target) begin
				r = $urandom_range(99);
				if (r < 10)
					send_message(0);
				else if (r < 75)
					send_message($urandom_range(8, 1));
				else if (r < 95)
					send_message($urandom_range(20, 9));
				else
					send_message($urandom_range(64, 21));
			end
		end

		s_tvalid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_hashes.size() != 0)
			n_errors++;
		$display("Sent %0d items, checked %0d hashes, %0d seed writes, %0d errors",
			items_sent, hashes_seen, seed_writes, n_errors);
		$display("Covered three idling profiles and a long output stall backing into the input");
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/murmur_pkg.sv
rtl/core/murmur_dp.sv
rtl/core/murmur_ctrl.sv
rtl/core/murmur2a_incremental_hash.sv
bench/tb_top.sv
